[rtl/link_heartbeat_and_wifi_negotiator_core_macros.svh]
// Assertion helpers for the heartbeat and wifi negotiator core.
// Each check is clocked on aclk and disabled while aresetn is low.
`ifndef LINK_HEARTBEAT_AND_WIFI_NEGOTIATOR_CORE_MACROS_SVH
`define LINK_HEARTBEAT_AND_WIFI_NEGOTIATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LHWN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lhwn check failed");
`define LHWN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lhwn check failed");
`else
`define LHWN_ASSERT_IMP(lbl, ante, cons)
`define LHWN_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/lhwn_pkg.sv]
package lhwn_pkg;

    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIFI_MODE    = 3'd0,
        CFG_LOSS_TIMEOUT = 3'd1,
        CFG_FIRST_WAIT   = 3'd2,
        CFG_WAIT_SPAN    = 3'd3,
        CFG_BEAT_BASE    = 3'd4,
        CFG_BEAT_SPAN    = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_AP   = 2'd1,
        MODE_STA  = 2'd2,
        MODE_AUTO = 2'd3
    } wifi_mode_t;

    typedef enum logic [1:0] {
        ST_OFF      = 2'd0,
        ST_CONN     = 2'd1,
        ST_STA_WAIT = 2'd2,
        ST_AP_WAIT  = 2'd3
    } auto_state_t;

    localparam logic [CFG_W-1:0] LOSS_TIMEOUT_RST = 20'd5000;
    localparam logic [CFG_W-1:0] FIRST_WAIT_RST   = 20'd10000;
    localparam logic [CFG_W-1:0] WAIT_SPAN_RST    = 20'd10000;
    localparam logic [CFG_W-1:0] BEAT_BASE_RST    = 20'd500;
    localparam logic [CFG_W-1:0] BEAT_SPAN_RST    = 20'd1000;

endpackage

[rtl/link_heartbeat_and_wifi_negotiator_core.sv]
// Link heartbeat and wifi mode negotiator, one request per time tick.
//
// Input channel (s_*): one request per tick, carrying the partner heartbeat
// flag and two random fractions over 2^RAND_BITS. Result channel (m_*): one
// result per request with the sent heartbeat, enable levels, link status and
// automatic negotiation state after that tick.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr at the
// clock edge; unknown indexes are dropped. Write only while the block is idle.
//
// Pipeline: an accepted request passes one input register, then a single
// pass of timer, link and mode logic into the result register, which
// raises m_valid. Throughput is one request per clock while the receiver
// keeps taking results; the two span multipliers feeding the saturating
// reloads set the critical path.
// Reset (aresetn low, synchronous) restores the register defaults, arms the
// heartbeat timer to fire on the first tick and parks negotiation in
// station wait. When the receiver stalls, the result register holds, the
// input register fills and s_ready then drops until the result is taken.
`include "link_heartbeat_and_wifi_negotiator_core_macros.svh"

module link_heartbeat_and_wifi_negotiator_core #(
    parameter int TIMER_BITS = 21,
    parameter int RAND_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [lhwn_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [lhwn_pkg::CFG_W-1:0]     cfg_wdata,
    // tick requests
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_heartbeat_seen,
    input  logic [RAND_BITS-1:0]           s_rand_beat,
    input  logic [RAND_BITS-1:0]           s_rand_wait,
    // results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_send_beat,
    output logic                           m_beat_payload,
    output logic                           m_ap_enable,
    output logic                           m_station_enable,
    output logic                           m_link_up,
    output logic                           m_link_changed,
    output logic [1:0]                     m_negotiation_state
);

    import lhwn_pkg::*;

    // Width that holds both a config value plus one carry bit and a full timer
    localparam int SUM_W  = ((CFG_W > TIMER_BITS) ? CFG_W : TIMER_BITS) + 1;
    localparam int PROD_W = CFG_W + RAND_BITS;
    localparam logic [SUM_W-1:0] TMAX_EXT =
        {{(SUM_W-TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = {{(TIMER_BITS-1){1'b0}}, 1'b1};

    // Clamp a wide value to the largest timer count
    function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [SUM_W-1:0] v);
        logic [TIMER_BITS-1:0] r;
        if (v > TMAX_EXT) begin
            r = {TIMER_BITS{1'b1}};
        end else begin
            r = v[TIMER_BITS-1:0];
        end
        return r;
    endfunction

    // base + ((span * frac) >> RAND_BITS), saturated to the timer width
    function automatic logic [TIMER_BITS-1:0] rand_reload(
        input logic [CFG_W-1:0]     base,
        input logic [CFG_W-1:0]     span,
        input logic [RAND_BITS-1:0] frac
    );
        logic [PROD_W-1:0] prod;
        logic [CFG_W:0]    sum;
        prod = PROD_W'(span) * PROD_W'(frac);
        sum  = {1'b0, base} + {1'b0, prod[PROD_W-1:RAND_BITS]};
        return sat_timer(SUM_W'(sum));
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    wifi_mode_t       wifi_mode_reg;
    logic [CFG_W-1:0] loss_timeout_reg;
    logic [CFG_W-1:0] first_wait_reg;
    logic [CFG_W-1:0] wait_span_reg;
    logic [CFG_W-1:0] beat_base_reg;
    logic [CFG_W-1:0] beat_span_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wifi_mode_reg    <= MODE_AUTO;
            loss_timeout_reg <= LOSS_TIMEOUT_RST;
            first_wait_reg   <= FIRST_WAIT_RST;
            wait_span_reg    <= WAIT_SPAN_RST;
            beat_base_reg    <= BEAT_BASE_RST;
            beat_span_reg    <= BEAT_SPAN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WIFI_MODE:    wifi_mode_reg    <= wifi_mode_t'(cfg_wdata[1:0]);
                CFG_LOSS_TIMEOUT: loss_timeout_reg <= cfg_wdata;
                CFG_FIRST_WAIT:   first_wait_reg   <= cfg_wdata;
                CFG_WAIT_SPAN:    wait_span_reg    <= cfg_wdata;
                CFG_BEAT_BASE:    beat_base_reg    <= cfg_wdata;
                CFG_BEAT_SPAN:    beat_span_reg    <= cfg_wdata;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: input register feeds result register
    // ---------------------------------------------------------------
    logic                 in_valid_reg;
    logic                 in_seen_reg;
    logic [RAND_BITS-1:0] in_rand_beat_reg;
    logic [RAND_BITS-1:0] in_rand_wait_reg;
    logic                 m_valid_reg;
    logic                 advance;
    logic                 s_accept;

    // Advance when the input register holds a request and the result slot is empty or being drained
    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_seen_reg      <= s_heartbeat_seen;
            in_rand_beat_reg <= s_rand_beat;
            in_rand_wait_reg <= s_rand_wait;
        end
    end

    // ---------------------------------------------------------------
    // Block state
    // ---------------------------------------------------------------
    logic [TIMER_BITS-1:0] beat_timer_reg,    beat_timer_next;
    logic [TIMER_BITS-1:0] silence_count_reg, silence_count_next;
    logic [TIMER_BITS-1:0] wait_count_reg,    wait_count_next;
    logic [TIMER_BITS-1:0] wait_limit_reg,    wait_limit_next;
    logic                  link_flag_reg,     link_flag_next;
    wifi_mode_t            applied_mode_reg;
    auto_state_t           auto_state_reg,    auto_state_next;
    logic                  ap_en_reg,         ap_en_next;
    logic                  sta_en_reg,        sta_en_next;

    logic                  send_now;
    logic                  payload_now;
    auto_state_t           auto_start;
    logic [TIMER_BITS-1:0] wait_count_inc;
    logic                  wait_expired;
    logic                  auto_run;

    // Heartbeat timer: fire on zero and reload, else count down
    always_comb begin
        send_now    = (beat_timer_reg == '0);
        payload_now = send_now && link_flag_reg;
        if (send_now) begin
            beat_timer_next = rand_reload(beat_base_reg, beat_span_reg, in_rand_beat_reg);
        end else begin
            beat_timer_next = beat_timer_reg - TIMER_ONE;
        end
    end

    // Link supervision: clear silence on a heartbeat, drop link on timeout
    always_comb begin
        link_flag_next = link_flag_reg;
        if (in_seen_reg) begin
            silence_count_next = '0;
            link_flag_next     = 1'b1;
        end else if (silence_count_reg == {TIMER_BITS{1'b1}}) begin
            silence_count_next = silence_count_reg;
        end else begin
            silence_count_next = silence_count_reg + TIMER_ONE;
        end
        if (SUM_W'(silence_count_next) > SUM_W'(loss_timeout_reg)) begin
            link_flag_next = 1'b0;
        end
    end

    // Entering automatic mode restarts negotiation from off
    assign auto_run   = (wifi_mode_reg == MODE_AUTO);
    assign auto_start = (applied_mode_reg != MODE_AUTO) ? ST_OFF : auto_state_reg;
    assign wait_count_inc = (wait_count_reg == {TIMER_BITS{1'b1}}) ?
                            wait_count_reg : (wait_count_reg + TIMER_ONE);
    assign wait_expired   = (wait_count_inc > wait_limit_reg);

    // Negotiation next state
    always_comb begin
        auto_state_next = auto_state_reg;
        if (auto_run) begin
            case (auto_start)
                ST_OFF: auto_state_next = ST_STA_WAIT;
                ST_STA_WAIT: begin
                    if (link_flag_next) begin
                        auto_state_next = ST_CONN;
                    end else if (wait_expired) begin
                        auto_state_next = ST_AP_WAIT;
                    end else begin
                        auto_state_next = ST_STA_WAIT;
                    end
                end
                ST_AP_WAIT: begin
                    if (link_flag_next) begin
                        auto_state_next = ST_CONN;
                    end else if (wait_expired) begin
                        auto_state_next = ST_STA_WAIT;
                    end else begin
                        auto_state_next = ST_AP_WAIT;
                    end
                end
                ST_CONN: auto_state_next = link_flag_next ? ST_CONN : ST_OFF;
                default: auto_state_next = ST_OFF;
            endcase
        end
    end

    // Negotiation outputs: enables and phase wait counters
    always_comb begin
        ap_en_next      = ap_en_reg;
        sta_en_next     = sta_en_reg;
        wait_count_next = wait_count_reg;
        wait_limit_next = wait_limit_reg;
        if (auto_run) begin
            case (auto_start)
                ST_OFF: begin
                    ap_en_next      = 1'b0;
                    sta_en_next     = 1'b1;
                    wait_count_next = '0;
                    wait_limit_next = sat_timer(SUM_W'(first_wait_reg));
                end
                ST_STA_WAIT, ST_AP_WAIT: begin
                    if (!link_flag_next && wait_expired) begin
                        // swap to the other role with a randomized wait
                        ap_en_next      = (auto_start == ST_STA_WAIT);
                        sta_en_next     = (auto_start == ST_AP_WAIT);
                        wait_count_next = '0;
                        wait_limit_next = rand_reload(first_wait_reg, wait_span_reg,
                                                      in_rand_wait_reg);
                    end else begin
                        wait_count_next = wait_count_inc;
                    end
                end
                default: ;  // connected: hold
            endcase
        end else if (applied_mode_reg != wifi_mode_reg) begin
            // fixed modes drive the enables once on a mode change
            ap_en_next  = (wifi_mode_reg == MODE_AP);
            sta_en_next = (wifi_mode_reg == MODE_STA);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_timer_reg    <= '0;
            silence_count_reg <= '0;
            wait_count_reg    <= '0;
            wait_limit_reg    <= '0;
            link_flag_reg     <= 1'b0;
            applied_mode_reg  <= MODE_OFF;
            auto_state_reg    <= ST_STA_WAIT;
            ap_en_reg         <= 1'b0;
            sta_en_reg        <= 1'b0;
        end else if (advance) begin
            beat_timer_reg    <= beat_timer_next;
            silence_count_reg <= silence_count_next;
            wait_count_reg    <= wait_count_next;
            wait_limit_reg    <= wait_limit_next;
            link_flag_reg     <= link_flag_next;
            applied_mode_reg  <= wifi_mode_reg;
            auto_state_reg    <= auto_state_next;
            ap_en_reg         <= ap_en_next;
            sta_en_reg        <= sta_en_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic        m_send_beat_reg;
    logic        m_beat_payload_reg;
    logic        m_ap_enable_reg;
    logic        m_station_enable_reg;
    logic        m_link_up_reg;
    logic        m_link_changed_reg;
    auto_state_t m_state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_send_beat_reg      <= send_now;
            m_beat_payload_reg   <= payload_now;
            m_ap_enable_reg      <= ap_en_next;
            m_station_enable_reg <= sta_en_next;
            m_link_up_reg        <= link_flag_next;
            m_link_changed_reg   <= (link_flag_next != link_flag_reg);
            m_state_reg          <= auto_state_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_send_beat         = m_send_beat_reg;
    assign m_beat_payload      = m_beat_payload_reg;
    assign m_ap_enable         = m_ap_enable_reg;
    assign m_station_enable    = m_station_enable_reg;
    assign m_link_up           = m_link_up_reg;
    assign m_link_changed      = m_link_changed_reg;
    assign m_negotiation_state = m_state_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `LHWN_ASSERT_NXT(a_link_change_flag, advance,
                     m_link_changed == (m_link_up != $past(link_flag_reg)))
    `LHWN_ASSERT_NXT(a_beat_on_expiry, advance && (beat_timer_reg == '0),
                     m_send_beat)
    `LHWN_ASSERT_IMP(a_enables_exclusive, m_valid_reg,
                     !(m_ap_enable && m_station_enable))
    `LHWN_ASSERT_NXT(a_input_held_on_stall, in_valid_reg && !advance,
                     in_valid_reg && $stable(in_rand_beat_reg))

endmodule

[bench/link_tick_checker.sv]
module link_tick_checker #(
    parameter int TIMER_BITS = 21,
    parameter int RAND_BITS  = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lhwn_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [lhwn_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_heartbeat_seen,
    input  logic [RAND_BITS-1:0]            s_rand_beat,
    input  logic [RAND_BITS-1:0]            s_rand_wait,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_send_beat,
    input  logic                            m_beat_payload,
    input  logic                            m_ap_enable,
    input  logic                            m_station_enable,
    input  logic                            m_link_up,
    input  logic                            m_link_changed,
    input  logic [1:0]                      m_negotiation_state,
    output int                              mismatches,
    output int                              outstanding
);

    import lhwn_pkg::*;

    localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

    // enable_levels bit 1 drives the access point, bit 0 the station
    localparam logic [1:0] EN_NONE = 2'b00;
    localparam logic [1:0] EN_STA  = 2'b01;
    localparam logic [1:0] EN_AP   = 2'b10;

    typedef logic [TIMER_BITS-1:0] tick_count_t;

    typedef struct packed {
        logic        send_beat;
        logic        beat_payload;
        logic        ap_enable;
        logic        station_enable;
        logic        link_up;
        logic        link_changed;
        auto_state_t negotiation_state;
    } tick_result_t;

    // register copies
    wifi_mode_t       mode_reg;
    logic [CFG_W-1:0] loss_timeout, first_wait, wait_span, beat_base, beat_span;

    // block state
    tick_count_t beat_timer, beat_interval, silence_cnt, wait_cnt, wait_lim;
    logic        link_flag;
    wifi_mode_t  applied_mode;
    auto_state_t auto_st;
    logic [1:0]  enable_levels;

    tick_result_t expected_ticks[$];

    function automatic tick_count_t timer_reload(input logic [CFG_W-1:0] base,
                                                 input logic [CFG_W-1:0] span,
                                                 input logic [RAND_BITS-1:0] frac);
        logic [63:0] sum;
        sum = 64'(base) + ((64'(span) * 64'(frac)) >> RAND_BITS);
        return (sum > TIMER_MAX) ? tick_count_t'(TIMER_MAX) : tick_count_t'(sum);
    endfunction

    function automatic tick_count_t sat_inc(input tick_count_t v);
        return (&v) ? v : v + tick_count_t'(1);
    endfunction

    task automatic restore_defaults();
        mode_reg      = MODE_AUTO;
        loss_timeout  = LOSS_TIMEOUT_RST;
        first_wait    = FIRST_WAIT_RST;
        wait_span     = WAIT_SPAN_RST;
        beat_base     = BEAT_BASE_RST;
        beat_span     = BEAT_SPAN_RST;
        beat_timer    = '0;
        beat_interval = '0;
        silence_cnt   = '0;
        wait_cnt      = '0;
        wait_lim      = '0;
        link_flag     = 1'b0;
        applied_mode  = MODE_OFF;
        auto_st       = ST_STA_WAIT;
        enable_levels = EN_NONE;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        case (idx)
            CFG_WIFI_MODE:    mode_reg     = wifi_mode_t'(data[1:0]);
            CFG_LOSS_TIMEOUT: loss_timeout = data;
            CFG_FIRST_WAIT:   first_wait   = data;
            CFG_WAIT_SPAN:    wait_span    = data;
            CFG_BEAT_BASE:    beat_base    = data;
            CFG_BEAT_SPAN:    beat_span    = data;
            default: ;
        endcase
    endtask

    task automatic step_negotiation(input logic [RAND_BITS-1:0] rw);
        case (auto_st)
            ST_OFF: begin
                enable_levels = EN_STA;
                wait_cnt      = '0;
                wait_lim      = tick_count_t'(first_wait);
                auto_st       = ST_STA_WAIT;
            end
            ST_STA_WAIT, ST_AP_WAIT: begin
                wait_cnt = sat_inc(wait_cnt);
                if (link_flag) begin
                    auto_st = ST_CONN;
                end else if (wait_cnt > wait_lim) begin
                    if (auto_st == ST_STA_WAIT) begin
                        enable_levels = EN_AP;
                        auto_st       = ST_AP_WAIT;
                    end else begin
                        enable_levels = EN_STA;
                        auto_st       = ST_STA_WAIT;
                    end
                    wait_cnt = '0;
                    wait_lim = timer_reload(first_wait, wait_span, rw);
                end
            end
            default: begin
                if (!link_flag) auto_st = ST_OFF;
            end
        endcase
    endtask

    task automatic advance_link_tick(input logic hb,
                                     input logic [RAND_BITS-1:0] rb,
                                     input logic [RAND_BITS-1:0] rw,
                                     output tick_result_t res);
        logic old_link;
        old_link = link_flag;
        res      = '0;

        // heartbeat transmit timer
        if (beat_timer == '0) begin
            res.send_beat    = 1'b1;
            res.beat_payload = link_flag;
            beat_interval    = timer_reload(beat_base, beat_span, rb);
            beat_timer       = beat_interval;
        end else begin
            beat_timer = beat_timer - tick_count_t'(1);
        end

        // partner heartbeat and loss detection
        if (hb) begin
            silence_cnt = '0;
            link_flag   = 1'b1;
        end else begin
            silence_cnt = sat_inc(silence_cnt);
        end
        if (64'(silence_cnt) > 64'(loss_timeout)) link_flag = 1'b0;

        // mode control
        if (mode_reg == MODE_AUTO) begin
            if (applied_mode != MODE_AUTO) auto_st = ST_OFF;
            step_negotiation(rw);
        end else if (applied_mode != mode_reg) begin
            enable_levels = (mode_reg == MODE_AP)  ? EN_AP  :
                            (mode_reg == MODE_STA) ? EN_STA : EN_NONE;
        end
        applied_mode = mode_reg;

        res.ap_enable         = enable_levels[1];
        res.station_enable    = enable_levels[0];
        res.link_up           = link_flag;
        res.link_changed      = (link_flag != old_link);
        res.negotiation_state = auto_st;
    endtask

    task automatic check_field(input string field, input logic [1:0] want,
                               input logic [1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        tick_result_t want;
        if (expected_ticks.size() == 0) begin
            $display("%0t: result with no request pending, expected none, got send=%0b link=%0b",
                     $time, m_send_beat, m_link_up);
            mismatches++;
        end else begin
            want = expected_ticks.pop_front();
            check_field("send_beat", 2'(want.send_beat), 2'(m_send_beat));
            check_field("beat_payload", 2'(want.beat_payload), 2'(m_beat_payload));
            check_field("ap_enable", 2'(want.ap_enable), 2'(m_ap_enable));
            check_field("station_enable", 2'(want.station_enable), 2'(m_station_enable));
            check_field("link_up", 2'(want.link_up), 2'(m_link_up));
            check_field("link_changed", 2'(want.link_changed), 2'(m_link_changed));
            check_field("negotiation_state", want.negotiation_state, m_negotiation_state);
        end
    endtask

    always @(posedge aclk) begin
        tick_result_t want;
        if (!aresetn) begin
            restore_defaults();
            expected_ticks.delete();
        end else begin
            if (cfg_wr_en) write_register(cfg_addr, cfg_wdata);
            // results always trail their request, so retire before predicting
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) begin
                advance_link_tick(s_heartbeat_seen, s_rand_beat, s_rand_wait, want);
                expected_ticks.push_back(want);
            end
        end
        outstanding = expected_ticks.size();
    end

endmodule

[bench/testbench.sv]
module testbench;

    import lhwn_pkg::*;

    localparam int RAND_BITS        = 16;
    localparam int RESET_CYCLES     = 11;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SINK_HOLD_CYCLES = 48;
    // pad after the last result is back, past the input and result registers
    localparam int DRAIN_PAD        = 4;
    localparam int IDLE_PCT         = 33;

    // index past the register list, must be dropped by the block
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam logic [CFG_W-1:0]     CFG_ALL_ONES  = '1;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 cfg_wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr         = '0;
    logic [CFG_W-1:0]     cfg_wdata        = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic                 s_heartbeat_seen = 1'b0;
    logic [RAND_BITS-1:0] s_rand_beat      = '0;
    logic [RAND_BITS-1:0] s_rand_wait      = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic                 m_send_beat;
    logic                 m_beat_payload;
    logic                 m_ap_enable;
    logic                 m_station_enable;
    logic                 m_link_up;
    logic                 m_link_changed;
    logic [1:0]           m_negotiation_state;

    int mismatches;
    int outstanding;

    // handshake bookkeeping; n_recv is registered, which only delays a drain
    int n_sent       = 0;
    int n_recv       = 0;
    int quiet_cycles = 0;

    // idle knobs and sink hold-off requests, owned by the stimulus process
    bit send_idle_on    = 1'b1;
    bit recv_idle_on    = 1'b1;
    int sink_hold_req   = 0;
    int sink_hold_taken = 0;

    always #1 aclk = ~aclk;

    link_heartbeat_and_wifi_negotiator_core u_dut (.*);

    link_tick_checker u_checker (.*);

    // Count results and quiet cycles; end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) n_recv <= n_recv + 1;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("link_heartbeat_and_wifi_negotiator_core test failed");
            $finish;
        end
    end

    // Result sink: random back-pressure, plus a long hold-off when the
    // stimulus asks for one so the block fills and stalls its input.
    initial begin
        sink_hold_taken = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold_req != sink_hold_taken) begin
                sink_hold_taken = sink_hold_req;
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !(recv_idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Pick a fraction: biased toward both ends of the range.
    function automatic logic [RAND_BITS-1:0] rand_frac();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return RAND_BITS'($urandom);
        endcase
    endfunction

    // Offer one tick request and hold it until the block takes it.
    task automatic send_tick(input logic hb, input logic [RAND_BITS-1:0] rb,
                             input logic [RAND_BITS-1:0] rw);
        while (send_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_heartbeat_seen <= hb;
        s_rand_beat      <= rb;
        s_rand_wait      <= rw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    // Drop valid and wait until every request has its result back.
    task automatic await_all_results();
        s_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    // Drive one register write; the caller lowers the enable afterwards.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        await_all_results();
        cfg_write(idx, data);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(input wifi_mode_t mode, input logic [CFG_W-1:0] loss,
                                 input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] span,
                                 input logic [CFG_W-1:0] bbase, input logic [CFG_W-1:0] bspan);
        await_all_results();
        cfg_write(CFG_WIFI_MODE, CFG_W'(mode));
        cfg_write(CFG_LOSS_TIMEOUT, loss);
        cfg_write(CFG_FIRST_WAIT, first);
        cfg_write(CFG_WAIT_SPAN, span);
        cfg_write(CFG_BEAT_BASE, bbase);
        cfg_write(CFG_BEAT_SPAN, bspan);
        cfg_wr_en <= 1'b0;
    endtask

    // Short timers so link loss, phase timeouts and beats all show up often.
    task automatic apply_small(input wifi_mode_t mode);
        apply_setting(mode, CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 10)),
                      CFG_W'($urandom_range(0, 24)), CFG_W'($urandom_range(0, 6)),
                      CFG_W'($urandom_range(0, 16)));
    endtask

    task automatic run_ticks(input int count, input int hb_pct);
        for (int i = 0; i < count; i++) begin
            send_tick($urandom_range(0, 99) < hb_pct, rand_frac(), rand_frac());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Shorten only the beat reload; the rest stays at reset values for
        // the first ticks so the first reload does not park the timer.
        cfg_write(CFG_BEAT_BASE, 20'd1);
        cfg_write(CFG_BEAT_SPAN, 20'd3);
        cfg_wr_en <= 1'b0;

        // First tick sends at once; fraction extremes, one partner beat.
        send_tick(1'b0, '0, '0);
        send_tick(1'b1, '1, '1);
        send_tick(1'b0, '1, '0);
        send_tick(1'b0, '0, '1);

        // Tight timers: link up then lost, connected drops to off, restart
        // next tick, station and access point waits alternate.
        apply_setting(MODE_AUTO, 20'd3, 20'd2, 20'd4, 20'd1, 20'd3);
        for (int i = 0; i < 12; i++) begin
            send_tick(1'b0, rand_frac(), (i % 2 == 0) ? '1 : '0);
        end
        send_tick(1'b1, '1, '0);
        send_tick(1'b0, '0, '1);
        send_tick(1'b0, '1, '1);

        // Fixed modes drive the enables once on entry; junk upper bits in
        // the mode write are masked, a write past the list is dropped.
        write_reg(CFG_WIFI_MODE, CFG_W'(MODE_AP));
        send_tick(1'b1, '0, '0);
        send_tick(1'b0, '1, '1);
        write_reg(CFG_WIFI_MODE, {{(CFG_W-2){1'b1}}, MODE_STA});
        send_tick(1'b0, '0, '1);
        send_tick(1'b1, '1, '0);
        write_reg(CFG_WIFI_MODE, CFG_W'(MODE_OFF));
        write_reg(CFG_IDX_SPARE, CFG_ALL_ONES);
        send_tick(1'b0, '0, '0);
        send_tick(1'b0, '1, '1);
        // all ones masks down to automatic mode, which restarts from off
        write_reg(CFG_WIFI_MODE, CFG_ALL_ONES);
        send_tick(1'b0, '0, '1);
        send_tick(1'b1, '1, '0);

        // Random negotiation with short timers, several settings.
        for (int k = 0; k < 3; k++) begin
            apply_small(MODE_AUTO);
            run_ticks(40, 10);
        end

        // All timers at zero, no idling on either side; hold the sink off
        // while requests keep coming so the input stalls.
        apply_setting(MODE_AUTO, '0, '0, '0, '0, '0);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        sink_hold_req++;
        run_ticks(100, 30);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;

        // Fixed modes: negotiation state is held while enables follow mode.
        apply_small(MODE_OFF);
        run_ticks(20, 20);
        apply_small(MODE_AP);
        run_ticks(20, 20);
        apply_small(MODE_STA);
        run_ticks(20, 20);

        // Widest silence window, huge random extra wait per phase.
        apply_setting(MODE_AUTO, CFG_ALL_ONES, 20'd3, CFG_ALL_ONES, 20'd2, 20'd5);
        run_ticks(100, 5);

        // Short timers again, with a pause until every result is back.
        for (int k = 0; k < 3; k++) begin
            apply_small(MODE_AUTO);
            run_ticks(20, 15);
            await_all_results();
            run_ticks(20, 15);
        end

        // Top of every wait and beat register; the next reload loads the
        // beat timer with a huge interval, so this runs last.
        apply_setting(MODE_AUTO, CFG_W'($urandom_range(0, 12)), CFG_ALL_ONES, CFG_ALL_ONES,
                      CFG_ALL_ONES, CFG_ALL_ONES);
        run_ticks(100, 10);

        await_all_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("link_heartbeat_and_wifi_negotiator_core test passed");
        end else begin
            $display("link_heartbeat_and_wifi_negotiator_core test failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/lhwn_pkg.sv
rtl/link_heartbeat_and_wifi_negotiator_core.sv
bench/link_tick_checker.sv
bench/testbench.sv
